FILE: hdl/fcaq_pkg.sv
// fcaq_pkg: shared constants and codes for the credit admission queue
// no dependencies; used by fcaq_ram and fifo_credit_admission_queue_unit
`default_nettype none

package fcaq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SIZE_BITS_DEF   = 10;
    localparam int TICKET_BITS_DEF = 16;
    localparam int HARD_MAX_RESET  = 64;

    typedef enum logic [1:0] {
        CMD_REQUEST  = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_CAPACITY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_QUEUED    = 3'd0,
        KIND_ADMITTED  = 3'd1,
        KIND_OVERSIZE  = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_CANCELLED = 3'd4,
        KIND_MISS      = 3'd5,
        KIND_RELEASED  = 3'd6,
        KIND_CAPSET    = 3'd7
    } t_kind;

endpackage

`default_nettype wire

FILE: hdl/fcaq_ram.sv
// fcaq_ram: queue entry storage, one write port and one registered read port
// depends on fcaq_pkg for default sizes
`default_nettype none

module fcaq_ram #(
    parameter int DEPTH = fcaq_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = fcaq_pkg::SIZE_BITS_DEF + fcaq_pkg::TICKET_BITS_DEF,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]     i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fifo_credit_admission_queue_unit.sv
// fifo_credit_admission_queue_unit: strict fifo admission control with credit reservation
// depends on fcaq_pkg and fcaq_ram
//
// usage:
//   input channel i_valid/o_ready carries one command transaction (request,
//   release, cancel, capacity update). o_ready is high only while the
//   sequencer is idle; one transaction is worked on at a time.
//   output channel o_valid/i_ready carries result transactions: the event's
//   own result, then one admitted result per head request that fits in the
//   free credit. o_last marks the final result of a command.
//   config port i_cfg_wr_en/i_cfg_wr_data writes hard_max_batch; it also
//   pulls the dynamic limit down to the new bound. write only while idle.
// sequencing:
//   request, release and capacity commands run an execute step, then a
//   head read and a head check that registers the result; each admitted
//   request repeats the head read and check. a cancel on a non-empty queue
//   first walks it through the single ram read port, a read and a compare
//   per entry searched and a read and a write per entry shifted.
// reset: synchronous active low; queue empty, ticket counter and reservation
//   zero, hard_max_batch 64, dynamic limit equal to it. no clearing pass.
// stall: while the receiver holds i_ready low the result register keeps its
//   transaction and the sequencer waits in its emit step.
`default_nettype none

module fifo_credit_admission_queue_unit #(
    parameter int QUEUE_DEPTH = fcaq_pkg::QUEUE_DEPTH_DEF,
    parameter int SIZE_BITS   = fcaq_pkg::SIZE_BITS_DEF,
    parameter int TICKET_BITS = fcaq_pkg::TICKET_BITS_DEF,
    parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [SIZE_BITS-1:0]   i_cfg_wr_data,
    // command channel
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [1:0]             i_cmd,
    input  wire logic [SIZE_BITS-1:0]   i_batch_size,
    input  wire logic [TICKET_BITS-1:0] i_ticket,
    input  wire logic signed [SIZE_BITS:0] i_capacity,
    // result channel
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_kind,
    output logic [TICKET_BITS-1:0]      o_out_ticket,
    output logic [SIZE_BITS-1:0]        o_out_size,
    output logic [SIZE_BITS-1:0]        o_reserved_now,
    output logic [SIZE_BITS-1:0]        o_limit_now,
    output logic [CNT_BITS-1:0]         o_waiting_count,
    output logic                        o_last
);

    import fcaq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int MW = TICKET_BITS + SIZE_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_SREAD  = 8'b0000_0100,
        S_SCMP   = 8'b0000_1000,
        S_MREAD  = 8'b0001_0000,
        S_MWRITE = 8'b0010_0000,
        S_HREAD  = 8'b0100_0000,
        S_HCHK   = 8'b1000_0000
    } t_state;

    // head-relative position to physical ram address, circular wrap
    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] base,
                                             input logic [IW-1:0] ofs);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, ofs};
        if (s >= (IW+1)'(QUEUE_DEPTH)) begin
            s = s - (IW+1)'(QUEUE_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    // sequencer and queue state
    t_state                 r_state, n_state;
    logic [IW-1:0]          r_head, n_head;
    logic [CNT_BITS-1:0]    r_count, n_count;
    logic [IW-1:0]          r_idx, n_idx;
    logic [TICKET_BITS-1:0] r_next_tk, n_next_tk;
    logic [SIZE_BITS-1:0]   r_reserved, n_reserved;
    logic [SIZE_BITS-1:0]   r_limit, n_limit;
    logic [SIZE_BITS-1:0]   r_hard_max;

    // latched command
    t_cmd                   r_cmd;
    logic [SIZE_BITS-1:0]   r_bsz;
    logic [TICKET_BITS-1:0] r_tk;
    logic [SIZE_BITS:0]     r_cap;

    // pending result, waits for the head fit check to know its last flag
    t_kind                  r_p_kind, n_p_kind;
    logic [TICKET_BITS-1:0] r_p_ticket, n_p_ticket;
    logic [SIZE_BITS-1:0]   r_p_size, n_p_size;

    // result register
    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic [TICKET_BITS-1:0] r_out_ticket;
    logic [SIZE_BITS-1:0]   r_out_size;
    logic [SIZE_BITS-1:0]   r_out_reserved;
    logic [SIZE_BITS-1:0]   r_out_limit;
    logic [CNT_BITS-1:0]    r_out_count;
    logic                   r_out_last;

    // ram port
    logic                   w_wr_en;
    logic [IW-1:0]          w_wr_addr;
    logic [MW-1:0]          w_wr_data;
    logic                   w_rd_en;
    logic [IW-1:0]          w_rd_addr;
    logic [MW-1:0]          w_rd_data;
    logic [TICKET_BITS-1:0] w_rd_ticket;
    logic [SIZE_BITS-1:0]   w_rd_size;

    // misc datapath
    logic                   w_accept;
    logic                   w_push;
    logic                   w_push_ok;
    logic [SIZE_BITS-1:0]   w_req_size;
    logic [SIZE_BITS-1:0]   w_cap_lim;
    logic [SIZE_BITS-1:0]   w_avail;
    logic                   w_fit;
    logic [CNT_BITS-1:0]    w_last_idx;
    logic [IW-1:0]          w_idx_nxt;
    logic                   w_full;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_push_ok   = !r_out_valid || i_ready;

    assign w_rd_ticket = w_rd_data[MW-1:SIZE_BITS];
    assign w_rd_size   = w_rd_data[SIZE_BITS-1:0];
    assign w_req_size  = (r_bsz == '0) ? SIZE_BITS'(1) : r_bsz;
    assign w_full      = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign w_last_idx  = r_count - CNT_BITS'(1);
    assign w_idx_nxt   = r_idx + IW'(1);

    // negative capacity clamps to zero, then capped by the hard bound
    always_comb begin
        w_cap_lim = r_cap[SIZE_BITS] ? '0 : r_cap[SIZE_BITS-1:0];
        if (w_cap_lim > r_hard_max) begin
            w_cap_lim = r_hard_max;
        end
    end

    // free credit, clamped at zero, and head fit test, which needs a non-empty queue
    assign w_avail = (r_limit > r_reserved) ? (r_limit - r_reserved) : '0;
    assign w_fit   = (r_count != '0) && (w_rd_size <= w_avail);

    // ram port steering per sequencer step
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = f_phys(r_head, r_idx);
        w_wr_data = w_rd_data;
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;
        case (r_state)
            S_EXEC: begin
                w_wr_en   = (r_cmd == CMD_REQUEST) && (w_req_size <= r_hard_max) && !w_full;
                w_wr_addr = f_phys(r_head, r_count[IW-1:0]);
                w_wr_data = {r_next_tk, w_req_size};
            end
            S_SREAD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_phys(r_head, r_idx);
            end
            S_MREAD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_phys(r_head, w_idx_nxt);
            end
            S_MWRITE: begin
                w_wr_en   = 1'b1;
            end
            S_HREAD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_head;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_next_tk  = r_next_tk;
        n_reserved = r_reserved;
        n_limit    = r_limit;
        n_p_kind   = r_p_kind;
        n_p_ticket = r_p_ticket;
        n_p_size   = r_p_size;
        w_push     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_HREAD;
                case (r_cmd)
                    CMD_REQUEST: begin
                        n_p_size = w_req_size;
                        if (w_req_size > r_hard_max) begin
                            n_p_kind   = KIND_OVERSIZE;
                            n_p_ticket = '0;
                        end else if (w_full) begin
                            n_p_kind   = KIND_FULL;
                            n_p_ticket = '0;
                        end else begin
                            n_p_kind   = KIND_QUEUED;
                            n_p_ticket = r_next_tk;
                            n_next_tk  = r_next_tk + TICKET_BITS'(1);
                            n_count    = r_count + CNT_BITS'(1);
                        end
                    end
                    CMD_RELEASE: begin
                        n_reserved = (r_reserved > r_bsz) ? (r_reserved - r_bsz) : '0;
                        n_p_kind   = KIND_RELEASED;
                        n_p_ticket = r_tk;
                        n_p_size   = r_bsz;
                    end
                    CMD_CANCEL: begin
                        n_p_kind   = KIND_MISS;
                        n_p_ticket = r_tk;
                        n_p_size   = '0;
                        n_idx      = '0;
                        if (r_count != '0) begin
                            n_state = S_SREAD;
                        end
                    end
                    CMD_CAPACITY: begin
                        n_limit    = w_cap_lim;
                        n_p_kind   = KIND_CAPSET;
                        n_p_ticket = '0;
                        n_p_size   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SREAD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (w_rd_ticket == r_tk) begin
                    n_p_kind = KIND_CANCELLED;
                    n_p_size = w_rd_size;
                    if (CNT_BITS'(r_idx) == w_last_idx) begin
                        n_count = r_count - CNT_BITS'(1);
                        n_state = S_HREAD;
                    end else begin
                        n_state = S_MREAD;
                    end
                end else if (CNT_BITS'(r_idx) == w_last_idx) begin
                    n_state = S_HREAD;
                end else begin
                    n_idx   = w_idx_nxt;
                    n_state = S_SREAD;
                end
            end
            S_MREAD: begin
                n_state = S_MWRITE;
            end
            S_MWRITE: begin
                // entry at idx took over its successor
                if (CNT_BITS'(w_idx_nxt) == w_last_idx) begin
                    n_count = r_count - CNT_BITS'(1);
                    n_state = S_HREAD;
                end else begin
                    n_idx   = w_idx_nxt;
                    n_state = S_MREAD;
                end
            end
            S_HREAD: begin
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (w_push_ok) begin
                    w_push = 1'b1;
                    if (w_fit) begin
                        n_reserved = r_reserved + w_rd_size;
                        n_head     = f_phys(r_head, IW'(1));
                        n_count    = r_count - CNT_BITS'(1);
                        n_p_kind   = KIND_ADMITTED;
                        n_p_ticket = w_rd_ticket;
                        n_p_size   = w_rd_size;
                        n_state    = S_HREAD;
                    end else begin
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_next_tk  <= '0;
            r_reserved <= '0;
            r_limit    <= SIZE_BITS'(HARD_MAX_RESET);
            r_hard_max <= SIZE_BITS'(HARD_MAX_RESET);
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_next_tk  <= n_next_tk;
            r_reserved <= n_reserved;
            r_limit    <= n_limit;
            // the user must keep config writes to idle; the block does not enforce it. that avoids a clash with n_limit
            if (i_cfg_wr_en) begin
                r_hard_max <= i_cfg_wr_data;
                if (r_limit > i_cfg_wr_data) begin
                    r_limit <= i_cfg_wr_data;
                end
            end
        end
    end

    // command capture and pending result, payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_cmd);
            r_bsz <= i_batch_size;
            r_tk  <= i_ticket;
            r_cap <= i_capacity;
        end
        r_p_kind   <= n_p_kind;
        r_p_ticket <= n_p_ticket;
        r_p_size   <= n_p_size;
    end

    // result register; values of reserved, limit and count are final here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_kind     <= r_p_kind;
            r_out_ticket   <= r_p_ticket;
            r_out_size     <= r_p_size;
            r_out_reserved <= r_reserved;
            r_out_limit    <= r_limit;
            r_out_count    <= r_count;
            r_out_last     <= !w_fit;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_out_ticket    = r_out_ticket;
    assign o_out_size      = r_out_size;
    assign o_reserved_now  = r_out_reserved;
    assign o_limit_now     = r_out_limit;
    assign o_waiting_count = r_out_count;
    assign o_last          = r_out_last;

    fcaq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (MW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // queue occupancy stays within the storage
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("waiting count beyond queue depth");

    // dynamic limit never above the hard bound
    a_limit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_limit <= r_hard_max)
        else $error("dynamic limit above hard bound");

    // a result never overwrites one still waiting on the receiver
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // an admission always leaves the queue one shorter
    a_admit_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_fit) |=> (r_count == $past(r_count) - CNT_BITS'(1)))
        else $error("admission did not pop the head");

    // the sequencer state stays one-hot
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule

`default_nettype wire

FILE: tb/sv/tb_fifo_credit_admission_queue_unit.sv
// tb_fifo_credit_admission_queue_unit: self-checking bench for the credit admission queue
// depends on fcaq_pkg and fifo_credit_admission_queue_unit; a directed table, then random
// phases over several hard_max_batch values, then a closing random run with no idling
`default_nettype none

module tb_fifo_credit_admission_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fcaq_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_LEN       = 40;

    // one result transaction as the block should produce it
    typedef struct {
        t_kind       kind;
        logic [15:0] tk;
        logic [9:0]  sz;
        logic [9:0]  resv;
        logic [9:0]  lim;
        logic [4:0]  waiting;
        logic        last;
    } t_adm_result;

    // one row of the directed table; pinned rows carry a hand-typed first result
    typedef struct {
        t_cmd        cmd;
        logic [9:0]  bsz;
        logic [15:0] tk;
        logic [10:0] cap;
        int          reps;
        bit          pin;
        t_kind       pin_kind;
        logic [15:0] pin_tk;
        logic [9:0]  pin_sz;
    } t_dir_row;

    // ------------------------------------------------------------------
    // dut signals, inputs all known from time zero
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [9:0]         i_cfg_wr_data = '0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [1:0]         i_cmd         = '0;
    logic [9:0]         i_batch_size  = '0;
    logic [15:0]        i_ticket      = '0;
    logic signed [10:0] i_capacity    = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [2:0]         o_kind;
    logic [15:0]        o_out_ticket;
    logic [9:0]         o_out_size;
    logic [9:0]         o_reserved_now;
    logic [9:0]         o_limit_now;
    logic [4:0]         o_waiting_count;
    logic               o_last;

    fifo_credit_admission_queue_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_batch_size    (i_batch_size),
        .i_ticket        (i_ticket),
        .i_capacity      (i_capacity),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_out_ticket    (o_out_ticket),
        .o_out_size      (o_out_size),
        .o_reserved_now  (o_reserved_now),
        .o_limit_now     (o_limit_now),
        .o_waiting_count (o_waiting_count),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shadow of the admission queue, used to predict every result
    // ------------------------------------------------------------------
    logic [15:0] q_tk [QDEPTH];
    logic [9:0]  q_sz [QDEPTH];
    int          q_n        = 0;
    logic [15:0] tk_next    = '0;
    logic [9:0]  resv       = '0;
    logic [9:0]  hmax       = 10'(HARD_MAX_RESET);
    logic [9:0]  dlim       = 10'(HARD_MAX_RESET);

    t_adm_result pred_res [QDEPTH + 1];
    int          pred_n;
    t_adm_result pending_results [$];

    // bench controls
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_go    = 1'b0;
    int err_cnt    = 0;
    int stall_cycles = 0;

    t_dir_row dir_tab [22];

    // record one result against the shadow state as it stands now
    function automatic void note_result(input t_kind k, input logic [15:0] t,
                                        input logic [9:0] s);
        pred_res[pred_n] = '{k, t, s, resv, dlim, 5'(q_n), 1'b0};
        pred_n++;
    endfunction

    // close the gap left by a removed waiting entry
    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < q_n; i++) begin
            q_tk[i] = q_tk[i + 1];
            q_sz[i] = q_sz[i + 1];
        end
        q_n--;
    endfunction

    // event result first, then the admission run from the head
    function automatic void predict_admission(input t_cmd cmd, input logic [9:0] bsz,
                                              input logic [15:0] tk,
                                              input logic [10:0] cap);
        logic [9:0]  sz;
        logic [9:0]  lim;
        logic [9:0]  avail;
        logic [15:0] t;
        bit          hit;
        pred_n = 0;
        case (cmd)
            CMD_REQUEST: begin
                sz = (bsz == 10'd0) ? 10'd1 : bsz;
                if (sz > hmax) begin
                    note_result(KIND_OVERSIZE, 16'd0, sz);
                end else if (q_n >= QDEPTH) begin
                    note_result(KIND_FULL, 16'd0, sz);
                end else begin
                    q_tk[q_n] = tk_next;
                    q_sz[q_n] = sz;
                    q_n++;
                    note_result(KIND_QUEUED, tk_next, sz);
                    tk_next = tk_next + 16'd1;
                end
            end
            CMD_RELEASE: begin
                resv = (resv > bsz) ? resv - bsz : 10'd0;
                note_result(KIND_RELEASED, tk, bsz);
            end
            CMD_CANCEL: begin
                hit = 1'b0;
                sz  = 10'd0;
                for (int i = 0; i < q_n; i++) begin
                    if (!hit && q_tk[i] == tk) begin
                        sz  = q_sz[i];
                        drop_entry(i);
                        hit = 1'b1;
                    end
                end
                note_result(hit ? KIND_CANCELLED : KIND_MISS, tk, sz);
            end
            CMD_CAPACITY: begin
                // negative measurements clamp to zero, then the hard bound applies
                lim = cap[10] ? 10'd0 : cap[9:0];
                if (lim > hmax) lim = hmax;
                dlim = lim;
                note_result(KIND_CAPSET, 16'd0, 10'd0);
            end
        endcase
        while (q_n > 0) begin
            avail = (dlim > resv) ? dlim - resv : 10'd0;
            if (q_sz[0] > avail) break;
            sz   = q_sz[0];
            t    = q_tk[0];
            resv = resv + sz;
            drop_entry(0);
            note_result(KIND_ADMITTED, t, sz);
        end
        pred_res[pred_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // offer one transaction, wait for acceptance, then queue what it should produce;
    // called right after a rising edge, returns at the accepting edge
    task automatic offer_cmd(input t_cmd cmd, input logic [9:0] bsz, input logic [15:0] tk,
                             input logic [10:0] cap, input bit pin, input t_kind pk,
                             input logic [15:0] pt, input logic [9:0] ps);
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_batch_size <= bsz;
        i_ticket     <= tk;
        i_capacity   <= cap;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_admission(cmd, bsz, tk, cap);
        // a pinned row checks its first result against the typed-in values
        if (pin) begin
            pred_res[0].kind = pk;
            pred_res[0].tk   = pt;
            pred_res[0].sz   = ps;
        end
        for (int i = 0; i < pred_n; i++) begin
            pending_results.insert(pending_results.size(), pred_res[i]);
        end
    endtask

    // random idle gap on the command side, taken one time in four while idling is on
    task automatic tx_gap();
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // stop offering until every queued result has arrived and the block is quiet
    task automatic settle_queue();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_hard_max(input logic [9:0] v);
        settle_queue();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        hmax = v;
        // a lower bound also pulls the dynamic limit down
        if (dlim > hmax) dlim = hmax;
    endtask

    // mostly sensible commands drawn from the shadow state, with some noise
    task automatic offer_random();
        t_cmd        cmd;
        int          roll;
        int          v;
        logic [9:0]  bsz;
        logic [15:0] tk;
        logic [10:0] cap;
        roll = $urandom_range(0, 99);
        bsz  = 10'($urandom);
        tk   = 16'($urandom);
        cap  = 11'($urandom);
        if (roll < 45) begin
            cmd = CMD_REQUEST;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = $urandom_range(0, hmax / 4 + 1);
                5, 6:          v = $urandom_range(0, hmax);
                7:             v = hmax;
                8:             v = hmax + 1;
                default:       v = $urandom_range(0, 1023);
            endcase
            bsz = (v > 1023) ? 10'd1023 : 10'(v);
        end else if (roll < 65) begin
            cmd = CMD_RELEASE;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: bsz = 10'($urandom_range(0, resv));
                6, 7:             bsz = 10'($urandom_range(0, 1023));
                8:                bsz = resv;
                default:          bsz = 10'd0;
            endcase
        end else if (roll < 85) begin
            cmd = CMD_CANCEL;
            v = $urandom_range(0, 99);
            if (q_n > 0 && v < 70) tk = q_tk[$urandom_range(0, q_n - 1)];
            else if (v < 85) tk = tk_next - 16'($urandom_range(1, 4));
        end else begin
            cmd = CMD_CAPACITY;
            case ($urandom_range(0, 3))
                0:       cap = 11'($urandom_range(0, hmax));
                1:       cap = 11'h400 | 11'($urandom_range(0, 1023));
                2:       cap = 11'($urandom);
                default: cap = 11'(hmax);
            endcase
        end
        offer_cmd(cmd, bsz, tk, cap, 1'b0, KIND_QUEUED, 16'd0, 10'd0);
    endtask

    function automatic t_dir_row mk(input t_cmd cmd, input logic [9:0] bsz,
                                    input logic [15:0] tk, input logic [10:0] cap,
                                    input int reps, input bit pin, input t_kind pk,
                                    input logic [15:0] pt, input logic [9:0] ps);
        t_dir_row r;
        r = '{cmd, bsz, tk, cap, reps, pin, pk, pt, ps};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready bursts, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_go) begin
                // long hold so results back up and the command side stalls
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_go = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic void cmp_field(input string tag, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want, got);
            err_cnt++;
        end
    endfunction

    // every accepted result transaction is matched against the oldest expectation
    t_adm_result mon_exp;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0d ticket %0d",
                         $time, o_kind, o_out_ticket);
                err_cnt++;
                $display("fifo_credit_admission_queue_unit regression: fail");
                $finish;
            end else begin
                mon_exp = pending_results[0];
                pending_results.delete(0);
                cmp_field("kind", 16'(mon_exp.kind), 16'(o_kind));
                cmp_field("out_ticket", mon_exp.tk, o_out_ticket);
                cmp_field("out_size", 16'(mon_exp.sz), 16'(o_out_size));
                cmp_field("reserved_now", 16'(mon_exp.resv), 16'(o_reserved_now));
                cmp_field("limit_now", 16'(mon_exp.lim), 16'(o_limit_now));
                cmp_field("waiting_count", 16'(mon_exp.waiting), 16'(o_waiting_count));
                cmp_field("last", 16'(mon_exp.last), 16'(o_last));
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("fifo_credit_admission_queue_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [9:0] phase_max [5];
        int         phase_len [5];
        // directed table, reset bound of 64 in force; comments give the state after each row
        dir_tab[0]  = mk(CMD_REQUEST, 10'd0, 16'h0000, 11'd0, 1, 1'b1,
                         KIND_QUEUED, 16'd0, 10'd1);        // size 0 raised, admitted at once
        dir_tab[1]  = mk(CMD_REQUEST, 10'd64, 16'h1234, 11'd0, 1, 1'b1,
                         KIND_QUEUED, 16'd1, 10'd64);       // does not fit, waits
        dir_tab[2]  = mk(CMD_REQUEST, 10'd65, 16'hffff, 11'd0, 1, 1'b1,
                         KIND_OVERSIZE, 16'd0, 10'd65);
        dir_tab[3]  = mk(CMD_REQUEST, 10'd1023, 16'h0000, 11'h7ff, 1, 1'b1,
                         KIND_OVERSIZE, 16'd0, 10'd1023);
        dir_tab[4]  = mk(CMD_RELEASE, 10'd0, 16'hffff, 11'd0, 1, 1'b1,
                         KIND_RELEASED, 16'hffff, 10'd0);   // zero release
        dir_tab[5]  = mk(CMD_RELEASE, 10'd1023, 16'h0000, 11'd0, 1, 1'b1,
                         KIND_RELEASED, 16'h0000, 10'd1023); // saturates, head admitted
        dir_tab[6]  = mk(CMD_CANCEL, 10'd0, 16'd1, 11'd0, 1, 1'b1,
                         KIND_MISS, 16'd1, 10'd0);          // already admitted
        dir_tab[7]  = mk(CMD_CAPACITY, 10'd0, 16'd0, 11'h400, 1, 1'b1,
                         KIND_CAPSET, 16'd0, 10'd0);        // most negative, limit 0
        dir_tab[8]  = mk(CMD_REQUEST, 10'd5, 16'd0, 11'd0, 1, 1'b1,
                         KIND_QUEUED, 16'd2, 10'd5);
        dir_tab[9]  = mk(CMD_REQUEST, 10'd7, 16'd0, 11'd0, 1, 1'b0,
                         KIND_QUEUED, 16'd0, 10'd0);
        dir_tab[10] = mk(CMD_CANCEL, 10'd0, 16'd2, 11'd0, 1, 1'b1,
                         KIND_CANCELLED, 16'd2, 10'd5);     // head removed
        dir_tab[11] = mk(CMD_CAPACITY, 10'd0, 16'd0, 11'd1023, 1, 1'b1,
                         KIND_CAPSET, 16'd0, 10'd0);        // capped to the hard bound
        dir_tab[12] = mk(CMD_RELEASE, 10'd64, 16'h5a5a, 11'd0, 1, 1'b0,
                         KIND_QUEUED, 16'd0, 10'd0);
        dir_tab[13] = mk(CMD_CAPACITY, 10'd0, 16'd0, 11'd7, 1, 1'b1,
                         KIND_CAPSET, 16'd0, 10'd0);
        dir_tab[14] = mk(CMD_REQUEST, 10'd1, 16'h00ff, 11'd0, 16, 1'b0,
                         KIND_QUEUED, 16'd0, 10'd0);        // fill all 16 slots
        dir_tab[15] = mk(CMD_REQUEST, 10'd3, 16'd0, 11'd0, 1, 1'b1,
                         KIND_FULL, 16'd0, 10'd3);
        dir_tab[16] = mk(CMD_CANCEL, 10'd0, 16'hffff, 11'd0, 1, 1'b1,
                         KIND_MISS, 16'hffff, 10'd0);       // full search, no hit
        dir_tab[17] = mk(CMD_CANCEL, 10'd0, 16'd19, 11'd0, 1, 1'b1,
                         KIND_CANCELLED, 16'd19, 10'd1);    // tail entry
        dir_tab[18] = mk(CMD_CANCEL, 10'd0, 16'd4, 11'd0, 1, 1'b1,
                         KIND_CANCELLED, 16'd4, 10'd1);     // head entry
        dir_tab[19] = mk(CMD_RELEASE, 10'd7, 16'd0, 11'd0, 1, 1'b0,
                         KIND_QUEUED, 16'd0, 10'd0);        // admission run of 7
        dir_tab[20] = mk(CMD_CAPACITY, 10'd0, 16'd0, 11'd1023, 1, 1'b0,
                         KIND_QUEUED, 16'd0, 10'd0);        // drains the rest
        dir_tab[21] = mk(CMD_REQUEST, 10'h2aa, 16'h5555, 11'h2aa, 1, 1'b1,
                         KIND_OVERSIZE, 16'd0, 10'h2aa);

        // random phases: widest bound, zero bound, unit bound, a small bound, then pressure
        phase_max[0] = 10'd1023; phase_len[0] = 100;
        phase_max[1] = 10'd0;    phase_len[1] = 35;
        phase_max[2] = 10'd1;    phase_len[2] = 40;
        phase_max[3] = 10'($urandom_range(2, 100)); phase_len[3] = 90;
        phase_max[4] = 10'd64;   phase_len[4] = 110;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[d]) begin
            for (int r = 0; r < dir_tab[d].reps; r++) begin
                offer_cmd(dir_tab[d].cmd, dir_tab[d].bsz, dir_tab[d].tk, dir_tab[d].cap,
                          dir_tab[d].pin, dir_tab[d].pin_kind, dir_tab[d].pin_tk,
                          dir_tab[d].pin_sz);
                tx_gap();
            end
        end

        for (int p = 0; p < 5; p++) begin
            write_hard_max(phase_max[p]);
            for (int k = 0; k < phase_len[p]; k++) begin
                // last phase: sender never pauses while the receiver holds off once
                if (p == 4 && k == 10) hold_go = 1'b1;
                offer_random();
                if (p != 4) begin
                    tx_gap();
                    if ($urandom_range(0, 59) == 0) settle_queue();
                end
            end
        end

        // closing run, no idling on either side from here on
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_hard_max(10'd1023);
        offer_cmd(CMD_CAPACITY, 10'd0, 16'd0, 11'd1023, 1'b0, KIND_QUEUED, 16'd0, 10'd0);
        for (int k = 0; k < TAIL_LEN; k++) offer_random();
        offer_cmd(CMD_CANCEL, 10'd0, 16'hffff, 11'd0, 1'b0, KIND_QUEUED, 16'd0, 10'd0);

        settle_queue();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("fifo_credit_admission_queue_unit regression: pass");
        end else begin
            $display("fifo_credit_admission_queue_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
